/* sv/plol_pkg.sv */
// Shared types, codes and helpers for the piecewise-linear opacity lookup.
// Depends on nothing; every other file imports this package.
`timescale 1ns / 1ps

package plol_pkg;

  localparam logic [15:0] ONE_Q15      = 16'd32768;
  localparam logic [15:0] NARROW_LIMIT = 16'd3;

  // Item modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] point_value;
    logic [15:0] point_opacity;
    logic [15:0] sample_value;
  } item_t;

  typedef struct packed {
    logic [15:0] opacity;
    logic        in_range;
    logic        insert_rejected;
    logic [4:0]  point_count;
  } result_t;

  typedef enum logic [3:0] {
    ST_INIT0,
    ST_INIT1,
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_Q_START,
    ST_Q_SCAN,
    ST_MUL0,
    ST_MUL1,
    ST_DIV_LOAD,
    ST_DIV,
    ST_QUOT,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic clear_table;
    logic set_reject;
    logic init_wr0;
    logic init_wr1;
    logic ins_read;
    logic ins_shift;
    logic ins_place;
    logic q_start;
    logic q_scan;
    logic set_avg;
    logic mul0;
    logic mul1;
    logic div_load;
    logic div_step;
    logic set_quot;
    logic respond;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic few;
    logic k_zero;
    logic pos_gt;
    logic first;
    logic last;
    logic hit;
    logic narrow;
    logic div_last;
  } status_t;

  // Clamp a Q1.15 input to 1.0
  function automatic logic [15:0] sat_q15(input logic [15:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

/* sv/plol_ctrl.sv */
// Sequencing state machine for the opacity lookup.
// Depends on plol_pkg; drives plol_dp through cmd_t and reads status_t.
`timescale 1ns / 1ps

module plol_ctrl
  import plol_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] mode,
  input  status_t    stat,
  output logic       busy,
  output cmd_t       cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT0;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT0: state_next = ST_INIT1;
      ST_INIT1: state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          unique case (mode)
            MODE_INSERT: state_next = stat.full ? ST_RESP : ST_INS_RD;
            MODE_QUERY:  state_next = stat.few ? ST_RESP : ST_Q_START;
            default:     state_next = ST_RESP;
          endcase
        end
      end
      ST_INS_RD:  state_next = stat.k_zero ? ST_RESP : ST_INS_CMP;
      ST_INS_CMP: state_next = stat.pos_gt ? ST_INS_RD : ST_RESP;
      ST_Q_START: state_next = ST_Q_SCAN;
      ST_Q_SCAN: begin
        if (!stat.first && stat.hit) begin
          state_next = stat.narrow ? ST_RESP : ST_MUL0;
        end else if (stat.last) begin
          state_next = ST_RESP;
        end
      end
      ST_MUL0:     state_next = ST_MUL1;
      ST_MUL1:     state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV:      state_next = stat.div_last ? ST_QUOT : ST_DIV;
      ST_QUOT:     state_next = ST_RESP;
      ST_RESP:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_INIT0: cmd.init_wr0 = 1'b1;
      ST_INIT1: cmd.init_wr1 = 1'b1;
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept      = 1'b1;
          cmd.clear_table = (mode == MODE_CLEAR);
          cmd.set_reject  = (mode == MODE_INSERT) && stat.full;
        end
      end
      ST_INS_RD: begin
        cmd.ins_read  = !stat.k_zero;
        cmd.ins_place = stat.k_zero;
      end
      ST_INS_CMP: begin
        cmd.ins_shift = stat.pos_gt;
        cmd.ins_place = !stat.pos_gt;
      end
      ST_Q_START: cmd.q_start = 1'b1;
      ST_Q_SCAN: begin
        cmd.q_scan  = 1'b1;
        cmd.set_avg = !stat.first && stat.hit && stat.narrow;
      end
      ST_MUL0:     cmd.mul0     = 1'b1;
      ST_MUL1:     cmd.mul1     = 1'b1;
      ST_DIV_LOAD: cmd.div_load = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_QUOT:     cmd.set_quot = 1'b1;
      ST_RESP:     cmd.respond  = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule

/* sv/plol_dp.sv */
// Datapath: control point memory, insert shifter, segment scan,
// shared multiplier and restoring divider. Depends on plol_pkg.
`timescale 1ns / 1ps

module plol_dp
  import plol_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  cmd_t    cmd,
  output status_t stat,
  output logic    done,
  output result_t result
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int HW = $clog2(MAX_POINTS + 1);

  // Point table, one write and one registered read a cycle
  logic [15:0] pos_mem [MAX_POINTS];
  logic [15:0] op_mem  [MAX_POINTS];
  logic [15:0] rd_pos, rd_op;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [15:0] wr_pos, wr_op;
  logic        wr_en;

  // Counters and captured transaction
  logic [HW-1:0] held, k, ra;
  logic [HW-1:0] k_less;
  logic [15:0] pv, po, sv;
  logic [15:0] prev_pos, prev_op;
  logic [15:0] seg_o0, seg_o1, seg_a, seg_d, seg_w;
  logic [15:0] w_now;
  logic [31:0] acc;
  logic [15:0] rem, nq;
  logic [16:0] trial, trial_sub;
  logic [3:0]  div_cnt;
  logic [16:0] op_sum;
  logic [15:0] opacity_r;
  logic        in_range_r, rej_r;

  assign k_less = k - HW'(1);
  assign w_now  = rd_pos - prev_pos;
  assign op_sum = {1'b0, prev_op} + {1'b0, rd_op};

  // Status to the controller
  always_comb begin
    stat          = '0;
    stat.full     = (held >= HW'(MAX_POINTS));
    stat.few      = (held < HW'(2));
    stat.k_zero   = (k == '0);
    stat.pos_gt   = (rd_pos > pv);
    stat.first    = (ra == HW'(1));
    stat.last     = (ra == held);
    stat.hit      = (prev_pos <= sv) && (sv <= rd_pos);
    stat.narrow   = (w_now <= NARROW_LIMIT);
    stat.div_last = (div_cnt == 4'd15);
  end

  // Read address select
  always_comb begin
    rd_addr = '0;
    if (cmd.ins_read) begin
      rd_addr = k_less[AW-1:0];
    end else if (cmd.q_scan) begin
      rd_addr = (ra < HW'(MAX_POINTS)) ? ra[AW-1:0] : '0;
    end
  end

  // Write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k[AW-1:0];
    wr_pos  = pv;
    wr_op   = po;
    if (cmd.init_wr0) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_pos  = '0;
      wr_op   = '0;
    end else if (cmd.init_wr1) begin
      wr_en   = 1'b1;
      wr_addr = AW'(1);
      wr_pos  = ONE_Q15;
      wr_op   = ONE_Q15;
    end else if (cmd.ins_shift) begin
      wr_en  = 1'b1;
      wr_pos = rd_pos;
      wr_op  = rd_op;
    end else if (cmd.ins_place) begin
      wr_en = 1'b1;
    end
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= wr_pos;
      op_mem[wr_addr]  <= wr_op;
    end
    rd_pos <= pos_mem[rd_addr];
    rd_op  <= op_mem[rd_addr];
  end

  // Point count
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= HW'(2);
    end else if (cmd.clear_table) begin
      held <= '0;
    end else if (cmd.ins_place) begin
      held <= held + HW'(1);
    end
  end

  // Capture, insert walk and scan counters
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pv <= sat_q15(item.point_value);
      po <= sat_q15(item.point_opacity);
      sv <= sat_q15(item.sample_value);
      k  <= held;
    end else if (cmd.ins_shift) begin
      k <= k_less;
    end
    if (cmd.q_start) begin
      ra <= HW'(1);
    end else if (cmd.q_scan) begin
      ra       <= ra + HW'(1);
      prev_pos <= rd_pos;
      prev_op  <= rd_op;
      seg_o0   <= prev_op;
      seg_o1   <= rd_op;
      seg_a    <= rd_pos - sv;
      seg_d    <= sv - prev_pos;
      seg_w    <= w_now;
    end
  end

  // Shared multiplier: o0*(w-d) then + o1*d
  always_ff @(posedge clk) begin
    if (cmd.mul0) begin
      acc <= 32'(seg_o0) * 32'(seg_a);
    end else if (cmd.mul1) begin
      acc <= acc + 32'(seg_o1) * 32'(seg_d);
    end
  end

  // Restoring divider, one quotient bit a cycle
  assign trial     = {rem, nq[15]};
  assign trial_sub = trial - {1'b0, seg_w};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem     <= {1'b0, acc[30:16]};
      nq      <= acc[15:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, seg_w}) begin
        rem <= trial_sub[15:0];
        nq  <= {nq[14:0], 1'b1};
      end else begin
        rem <= trial[15:0];
        nq  <= {nq[14:0], 1'b0};
      end
      div_cnt <= div_cnt + 4'd1;
    end
  end

  // Result fields built up during the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      opacity_r  <= '0;
      in_range_r <= 1'b0;
      rej_r      <= 1'b0;
    end else if (cmd.accept) begin
      opacity_r  <= '0;
      in_range_r <= 1'b0;
      rej_r      <= cmd.set_reject;
    end else if (cmd.set_avg) begin
      opacity_r  <= op_sum[16:1];
      in_range_r <= 1'b1;
    end else if (cmd.set_quot) begin
      opacity_r  <= nq;
      in_range_r <= 1'b1;
    end
  end

  // Output register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
    if (cmd.respond) begin
      result.opacity         <= opacity_r;
      result.in_range        <= in_range_r;
      result.insert_rejected <= rej_r;
      result.point_count     <= 5'(held);
    end
  end

endmodule

/* sv/piecewise_linear_opacity_lookup_top.sv */
// Top level of the piecewise-linear opacity lookup.
// Depends on plol_pkg, plol_ctrl and plol_dp.
//
// Usage:
//   An item (clear, insert or query) is taken on a rising edge with start
//   high and busy low. Exactly one result follows, shown on result for one
//   cycle with done high; the receiver takes it on that edge and cannot
//   stall it. busy drops in the cycle done rises, so the next transaction
//   may start while the result is still shown.
// Sequence, start edge to done:
//   clear, mode 3, rejected insert or query with under two points: straight
//   to the response state.
//   insert: a read and a compare state per point moved up, then the place.
//   query: the scan takes one point a cycle through the table read port
//   until a hit or the last point; a miss or narrow segment then responds,
//   and an interpolated query goes on through the multiply states and the
//   16-step divider.
// Reset: synchronous, rst high. Afterwards busy stays high in ST_INIT0 and
//   ST_INIT1 while the default points (0,0) and (1,1) are written into the table.
`timescale 1ns / 1ps

module piecewise_linear_opacity_lookup_top
  import plol_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  cmd_t    cmd;
  status_t stat;

  plol_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .mode (item.mode),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  plol_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .cmd   (cmd),
    .stat  (stat),
    .done  (done),
    .result(result)
  );

endmodule
